>>> rtl/core/ssvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo state variable filter package
// Default widths, configuration register indexes, filter modes and the
// sequencer state type and step codes shared by the filter.
// ----------------------------------------------------------------------------
package ssvf_pkg;

  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_STATE_WIDTH  = 32;
  localparam int DEF_COEF_WIDTH   = 18;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_COUNT  = 6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FILTER_MODE = 3'd0,
    CFG_OUTPUT_GAIN = 3'd1,
    CFG_COEF_ONE    = 3'd2,
    CFG_COEF_TWO    = 3'd3,
    CFG_DIRECT_GAIN = 3'd4,
    CFG_BAND_MIX    = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_LOW_PASS  = 2'd0,
    MODE_HIGH_PASS = 2'd1,
    MODE_BAND_PASS = 2'd2
  } filter_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } seq_state_t;

  localparam logic [2:0] STEP_X_C2    = 3'd0;
  localparam logic [2:0] STEP_C1      = 3'd1;
  localparam logic [2:0] STEP_D0_Z2   = 3'd2;
  localparam logic [2:0] STEP_D1_Z1   = 3'd3;
  localparam logic [2:0] STEP_DX      = 3'd4;
  localparam logic [2:0] STEP_GAIN    = 3'd5;
  localparam logic [2:0] STEP_WAIT    = 3'd6;
  localparam logic [2:0] STEP_OUT     = 3'd7;

endpackage

>>> rtl/core/stereo_state_variable_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo state variable filter
// Two-pole state variable filter for a stereo sample pair, with a selectable
// low-pass, high-pass or band-pass output, built around one shared multiplier.
// ----------------------------------------------------------------------------
// For each word the left and then the right channel each run eight steps
// through the single multiplier and its rounding stage; the flush state then
// moves the pair into the output register once it is free. The input is
// not ready during that time, but the finished pair waits in the output
// register, so a new word is taken while the previous result is pending.
// Any write to a defined configuration register clears all four
// integrators. Mode 3 updates the integrators and returns zeros.

module stereo_state_variable_filter_top #(
  parameter int SAMPLE_WIDTH = ssvf_pkg::DEF_SAMPLE_WIDTH,
  parameter int STATE_WIDTH  = ssvf_pkg::DEF_STATE_WIDTH,
  parameter int COEF_WIDTH   = ssvf_pkg::DEF_COEF_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // Fields from bit 0: in_left, in_right, zero padding.
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         in_tdata,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // Fields from bit 0: out_left, out_right, zero padding.
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         out_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic                                        cfg_we,
  input  logic [ssvf_pkg::CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [COEF_WIDTH-1:0]                       cfg_wdata
);

  import ssvf_pkg::*;

  localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int FRAC    = COEF_WIDTH - 4;
  localparam int PW      = COEF_WIDTH + 1 + STATE_WIDTH;
  localparam int WW      = PW + 1;

  localparam logic signed [WW-1:0] ST_MAX = {{(WW-STATE_WIDTH+1){1'b0}},
                                             {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [WW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [WW-1:0] SMP_MAX = {{(WW-SAMPLE_WIDTH+1){1'b0}},
                                              {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [WW-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);
  localparam logic [COEF_WIDTH-1:0] GAIN_UNITY = COEF_WIDTH'(1) << FRAC;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [WW-1:0] v
  );
    if (v > ST_MAX) begin
      return ST_MAX[STATE_WIDTH-1:0];
    end else if (v < ST_MIN) begin
      return ST_MIN[STATE_WIDTH-1:0];
    end
    return v[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [WW-1:0] v
  );
    if (v > SMP_MAX) begin
      return SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SMP_MIN) begin
      return SMP_MIN[SAMPLE_WIDTH-1:0];
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Rounds to nearest with ties away from zero, then saturates.
  function automatic logic signed [STATE_WIDTH-1:0] round_prod(
    input logic signed [PW-1:0] p
  );
    logic [PW-1:0]          mag;
    logic [PW-1:0]          rnd;
    logic signed [WW-1:0]   sv;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    rnd = (mag + HALF) >> FRAC;
    sv  = p[PW-1] ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});
    return sat_state(sv);
  endfunction

  seq_state_t                     state_r;
  logic [2:0]                     step_r;
  logic                           ch_r;

  logic [1:0]                     mode_r;
  logic [COEF_WIDTH-1:0]          gain_r;
  logic signed [COEF_WIDTH-1:0]   c1_r;
  logic signed [COEF_WIDTH-1:0]   c2_r;
  logic signed [COEF_WIDTH-1:0]   d0_r;
  logic signed [COEF_WIDTH-1:0]   d1_r;

  logic signed [STATE_WIDTH-1:0]  z1_r [2];
  logic signed [STATE_WIDTH-1:0]  z2_r [2];

  logic signed [SAMPLE_WIDTH-1:0] in_l_r;
  logic signed [SAMPLE_WIDTH-1:0] in_r_r;
  logic signed [STATE_WIDTH-1:0]  x_r;
  logic signed [STATE_WIDTH-1:0]  nz1_r;
  logic signed [STATE_WIDTH-1:0]  nz2_r;
  logic signed [STATE_WIDTH-1:0]  dx_r;
  logic signed [STATE_WIDTH-1:0]  t_r;
  logic signed [STATE_WIDTH-1:0]  band_r;
  logic signed [STATE_WIDTH-1:0]  q_r;
  logic signed [PW-1:0]           prod_r;

  logic signed [SAMPLE_WIDTH-1:0] res_l_r;
  logic signed [SAMPLE_WIDTH-1:0] res_r_r;
  logic signed [SAMPLE_WIDTH-1:0] out_l_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r_r;
  logic                           out_valid_r;

  logic signed [STATE_WIDTH-1:0]  z1_cur;
  logic signed [STATE_WIDTH-1:0]  z2_cur;
  logic signed [SAMPLE_WIDTH-1:0] in_cur;
  logic signed [COEF_WIDTH:0]     mul_a;
  logic signed [STATE_WIDTH-1:0]  mul_b;
  logic signed [SAMPLE_WIDTH-1:0] out_val;
  logic                           in_fire;
  logic                           cfg_hit;
  logic                           out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_hit    = cfg_we && (cfg_addr < CFG_ADDR_W'(CFG_COUNT));
  assign out_load   = (state_r == ST_FLUSH) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({out_r_r, out_l_r});

  assign z1_cur = z1_r[ch_r];
  assign z2_cur = z2_r[ch_r];
  assign in_cur = ch_r ? in_r_r : in_l_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      STEP_X_C2: begin
        mul_a = {c2_r[COEF_WIDTH-1], c2_r};
        mul_b = z1_cur;
      end
      STEP_C1: begin
        mul_a = {c1_r[COEF_WIDTH-1], c1_r};
        mul_b = x_r;
      end
      STEP_D0_Z2: begin
        mul_a = {d0_r[COEF_WIDTH-1], d0_r};
        mul_b = x_r;
      end
      STEP_D1_Z1: begin
        mul_a = {d1_r[COEF_WIDTH-1], d1_r};
        mul_b = z1_cur;
      end
      STEP_GAIN: begin
        mul_a = {1'b0, gain_r};
        mul_b = (mode_r == MODE_LOW_PASS) ? t_r : dx_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_LOW_PASS, MODE_HIGH_PASS: out_val = sat_sample(WW'(q_r));
      MODE_BAND_PASS:                out_val = sat_sample(WW'(q_r) + WW'(band_r));
      default:                       out_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ch_r    <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_RUN;
            step_r  <= '0;
            ch_r    <= 1'b0;
          end
        end
        ST_RUN: begin
          step_r <= step_r + 3'd1;
          if (step_r == STEP_OUT) begin
            ch_r <= ~ch_r;
            if (ch_r) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LOW_PASS;
      gain_r <= GAIN_UNITY;
      c1_r   <= '0;
      c2_r   <= '0;
      d0_r   <= '0;
      d1_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FILTER_MODE: mode_r <= cfg_wdata[1:0];
        CFG_OUTPUT_GAIN: gain_r <= cfg_wdata;
        CFG_COEF_ONE:    c1_r   <= cfg_wdata;
        CFG_COEF_TWO:    c2_r   <= cfg_wdata;
        CFG_DIRECT_GAIN: d0_r   <= cfg_wdata;
        CFG_BAND_MIX:    d1_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      z1_r[0] <= '0;
      z1_r[1] <= '0;
      z2_r[0] <= '0;
      z2_r[1] <= '0;
    end else if (state_r == ST_RUN && step_r == STEP_OUT) begin
      z1_r[ch_r] <= nz1_r;
      z2_r[ch_r] <= nz2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    q_r    <= round_prod(prod_r);
    if (in_fire) begin
      in_l_r <= in_tdata[SAMPLE_WIDTH-1:0];
      in_r_r <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
    if (state_r == ST_RUN) begin
      case (step_r)
        STEP_X_C2:  x_r   <= sat_state(WW'(in_cur) - WW'(z1_cur) - WW'(z2_cur));
        STEP_D0_Z2: nz2_r <= sat_state(WW'(z2_cur) + WW'(q_r));
        STEP_D1_Z1: nz1_r <= sat_state(WW'(z1_cur) + WW'(q_r));
        STEP_DX: begin
          dx_r <= q_r;
          t_r  <= sat_state(WW'(q_r) + WW'(nz2_r));
        end
        STEP_GAIN:  band_r <= q_r;
        STEP_OUT: begin
          if (ch_r) begin
            res_r_r <= out_val;
          end else begin
            res_l_r <= out_val;
          end
        end
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_l_r <= res_l_r;
      out_r_r <= res_r_r;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state lost its one-hot code");

  a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_r != STEP_OUT)
      |=> (state_r == ST_RUN && step_r == $past(step_r) + 3'd1))
    else $error("sequencer step did not advance");

  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (z1_r[0] == '0 && z1_r[1] == '0 && z2_r[0] == '0 && z2_r[1] == '0))
    else $error("integrators not cleared by configuration write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN && step_r == STEP_X_C2 && !ch_r))
    else $error("accepted word did not start the sequencer");

endmodule
